FILE: src/button_click_classifier_core_macros.svh
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_MACROS_SVH

// a holds at an edge, b must hold at the same edge
`ifndef NO_ASSERTIONS
`define BCC_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("bcc assertion failed");
`else
`define BCC_ASSERT_SAME(label, clk, rst, a, b)
`endif

// a holds at an edge, b must hold at the next edge
`ifndef NO_ASSERTIONS
`define BCC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("bcc assertion failed");
`else
`define BCC_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

FILE: src/bcc_pkg.sv
package bcc_pkg;

  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_MS     = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS_MS   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOUBLE_CLICK_MS = 2'd2;

  localparam logic [15:0] DEBOUNCE_MS_RESET     = 16'd50;
  localparam logic [15:0] LONG_PRESS_MS_RESET   = 16'd1000;
  localparam logic [15:0] DOUBLE_CLICK_MS_RESET = 16'd300;

  typedef struct packed {
    logic [31:0] time_ms;
    logic        pressed;
    logic        ignore_request;
  } sample_t;

  typedef struct packed {
    logic        stable_pressed;
    logic        single_event;
    logic        double_event;
    logic        long_event;
    logic [15:0] single_total;
    logic [15:0] double_total;
    logic [15:0] long_total;
  } result_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] double_click_ms;
  } cfg_t;

endpackage

FILE: src/bcc_cfg_regs.sv
module bcc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [15:0]                         cfg_data,
  output bcc_pkg::cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= bcc_pkg::DEBOUNCE_MS_RESET;
      cfg.long_press_ms   <= bcc_pkg::LONG_PRESS_MS_RESET;
      cfg.double_click_ms <= bcc_pkg::DOUBLE_CLICK_MS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bcc_pkg::REG_DEBOUNCE_MS:     cfg.debounce_ms     <= cfg_data;
        bcc_pkg::REG_LONG_PRESS_MS:   cfg.long_press_ms   <= cfg_data;
        bcc_pkg::REG_DOUBLE_CLICK_MS: cfg.double_click_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/bcc_step.sv
module bcc_step #(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  bcc_pkg::sample_t sample,
  input  bcc_pkg::cfg_t    cfg,
  output bcc_pkg::result_t result
);

  logic                   prev_raw;
  logic [TIME_WIDTH-1:0]  raw_change_time;
  logic                   stable_level;
  logic [TIME_WIDTH-1:0]  press_start_time;
  logic                   long_reported;
  logic                   first_click_pending;
  logic [TIME_WIDTH-1:0]  first_click_time;
  logic                   ignore_until_release;
  logic [COUNT_WIDTH-1:0] single_count;
  logic [COUNT_WIDTH-1:0] double_count;
  logic [COUNT_WIDTH-1:0] long_count;

  logic [TIME_WIDTH-1:0]  raw_change_time_next;
  logic                   stable_level_next;
  logic [TIME_WIDTH-1:0]  press_start_time_next;
  logic                   long_reported_next;
  logic                   first_click_pending_next;
  logic [TIME_WIDTH-1:0]  first_click_time_next;
  logic                   ignore_until_release_next;
  logic [COUNT_WIDTH-1:0] single_count_next;
  logic [COUNT_WIDTH-1:0] double_count_next;
  logic [COUNT_WIDTH-1:0] long_count_next;

  logic [TIME_WIDTH-1:0]  t;
  logic [TIME_WIDTH-1:0]  debounce_t;
  logic [TIME_WIDTH-1:0]  long_press_t;
  logic [TIME_WIDTH-1:0]  double_click_t;
  logic                   raw;
  logic                   ev_single;
  logic                   ev_double;
  logic                   ev_long;

  always_comb begin
    t              = TIME_WIDTH'(sample.time_ms);
    raw            = sample.pressed;
    debounce_t     = TIME_WIDTH'(cfg.debounce_ms);
    long_press_t   = TIME_WIDTH'(cfg.long_press_ms);
    double_click_t = TIME_WIDTH'(cfg.double_click_ms);

    ignore_until_release_next = ignore_until_release | sample.ignore_request;
    raw_change_time_next      = (raw != prev_raw) ? t : raw_change_time;
    stable_level_next         = stable_level;
    press_start_time_next     = press_start_time;
    long_reported_next        = long_reported;
    first_click_pending_next  = first_click_pending;
    first_click_time_next     = first_click_time;
    single_count_next         = single_count;
    double_count_next         = double_count;
    long_count_next           = long_count;
    ev_single                 = 1'b0;
    ev_double                 = 1'b0;
    ev_long                   = 1'b0;

    // debounced edge
    if (((t - raw_change_time_next) > debounce_t) && (raw != stable_level)) begin
      stable_level_next = raw;
      if (raw) begin
        press_start_time_next = t;
        long_reported_next    = 1'b0;
      end else if (ignore_until_release_next) begin
        ignore_until_release_next = 1'b0;
      end else if (long_reported || ((t - press_start_time) >= long_press_t)) begin
        if (!long_reported) begin
          long_count_next = long_count + COUNT_WIDTH'(1);
          ev_long         = 1'b1;
        end
        first_click_pending_next = 1'b0;
      end else if (first_click_pending &&
                   ((t - first_click_time) <= double_click_t)) begin
        double_count_next        = double_count + COUNT_WIDTH'(1);
        ev_double                = 1'b1;
        first_click_pending_next = 1'b0;
      end else begin
        first_click_pending_next = 1'b1;
        first_click_time_next    = t;
      end
    end

    // long press while held
    if (stable_level_next && !long_reported_next && !ignore_until_release_next &&
        ((t - press_start_time_next) >= long_press_t)) begin
      long_count_next    = long_count_next + COUNT_WIDTH'(1);
      long_reported_next = 1'b1;
      ev_long            = 1'b1;
    end

    // single click timeout
    if (first_click_pending_next && !ignore_until_release_next &&
        ((t - first_click_time_next) > double_click_t)) begin
      single_count_next        = single_count_next + COUNT_WIDTH'(1);
      first_click_pending_next = 1'b0;
      ev_single                = 1'b1;
    end

    result.stable_pressed = stable_level_next;
    result.single_event   = ev_single;
    result.double_event   = ev_double;
    result.long_event     = ev_long;
    result.single_total   = 16'(single_count_next);
    result.double_total   = 16'(double_count_next);
    result.long_total     = 16'(long_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw             <= 1'b0;
      raw_change_time      <= '0;
      stable_level         <= 1'b0;
      press_start_time     <= '0;
      long_reported        <= 1'b0;
      first_click_pending  <= 1'b0;
      first_click_time     <= '0;
      ignore_until_release <= 1'b0;
      single_count         <= '0;
      double_count         <= '0;
      long_count           <= '0;
    end else if (fire) begin
      prev_raw             <= raw;
      raw_change_time      <= raw_change_time_next;
      stable_level         <= stable_level_next;
      press_start_time     <= press_start_time_next;
      long_reported        <= long_reported_next;
      first_click_pending  <= first_click_pending_next;
      first_click_time     <= first_click_time_next;
      ignore_until_release <= ignore_until_release_next;
      single_count         <= single_count_next;
      double_count         <= double_count_next;
      long_count           <= long_count_next;
    end
  end

endmodule

FILE: src/button_click_classifier_core.sv
// Debounced button click classifier.
// sample channel (sample_valid / sample_ready / sample): one timestamped raw
// button level per item, with an ignore-until-release request bit.
// result channel (result_valid / result_ready / result): exactly one item per
// sample, carrying the debounced level, the single, double and long click
// flags for that sample and the three wrapping click totals.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
// debounce, long press and double click times; always ready, unknown
// indexes are dropped. Write only while no sample is in flight.
// A sample accepted into the input register is classified there by combinational
// logic, and its result is loaded into the result register when it advances.
// Throughput: one sample per cycle while result_ready is high; the state loop
// closes through bcc_step's state registers, one pass of compares and adds.
// Reset clears all click state and counters and loads the default times.
// A stalled result holds its register; one further sample may sit in the
// input register, after which sample_ready drops until result_ready returns.
`include "button_click_classifier_core_macros.svh"

module button_click_classifier_core #(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  bcc_pkg::sample_t                    sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output bcc_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [15:0]                         cfg_data
);

  bcc_pkg::cfg_t    cfg;
  bcc_pkg::sample_t stage;
  logic             stage_valid;
  logic             advance;
  bcc_pkg::result_t step_result;

  assign advance      = stage_valid && (!result_valid || result_ready);
  assign sample_ready = !stage_valid || advance;

  bcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcc_step #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .sample (stage),
    .cfg    (cfg),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      stage <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  `BCC_ASSERT_NEXT(a_stage_holds, clk, rst, stage_valid && !advance, stage_valid)
  `BCC_ASSERT_NEXT(a_advance_gives_result, clk, rst, advance, result_valid)
  `BCC_ASSERT_SAME(a_no_single_with_double, clk, rst, result_valid, !(result.single_event && result.double_event))
  `BCC_ASSERT_SAME(a_no_long_with_double, clk, rst, result_valid, !(result.long_event && result.double_event))

endmodule

FILE: tb/tb_button_click_classifier_core.sv
`timescale 1ns / 1ps

module tb_button_click_classifier_core;

  localparam logic [bcc_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic sample_valid;
  logic sample_ready;
  bcc_pkg::sample_t sample_in;
  logic result_valid;
  logic result_ready;
  bcc_pkg::result_t result_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [bcc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [15:0] cfg_data;

  button_click_classifier_core DUT (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample_in),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // classifier copy: timing settings
  logic [15:0] cfg_debounce;
  logic [15:0] cfg_long;
  logic [15:0] cfg_double;

  // classifier copy: click state
  logic        lvl_prev;
  logic [31:0] lvl_change_ms;
  logic        lvl_stable;
  logic [31:0] press_ms;
  logic        long_flagged;
  logic        click_waiting;
  logic [31:0] click_ms;
  logic        ignoring;
  logic [15:0] clicks_single;
  logic [15:0] clicks_double;
  logic [15:0] clicks_long;

  bcc_pkg::result_t expected_results[$];
  bcc_pkg::result_t want;

  logic [31:0] now;
  bit steady_flow;
  int unsigned ready_hold;
  int unsigned items_sent;
  int unsigned cfg_writes;
  int unsigned mismatches;
  int unsigned seen_single;
  int unsigned seen_double;
  int unsigned seen_long;

  function automatic logic [31:0] since(input logic [31:0] t, input logic [31:0] then_ms);
    return t - then_ms;
  endfunction

  function automatic bcc_pkg::result_t classify(input bcc_pkg::sample_t s);
    bcc_pkg::result_t r;
    logic [31:0] t;
    logic raw;
    t = s.time_ms;
    raw = s.pressed;
    r = '0;
    if (s.ignore_request) ignoring = 1'b1;
    if (raw != lvl_prev) lvl_change_ms = t;
    if (since(t, lvl_change_ms) > 32'(cfg_debounce) && raw != lvl_stable) begin
      lvl_stable = raw;
      if (raw) begin
        press_ms = t;
        long_flagged = 1'b0;
      end else if (ignoring) begin
        ignoring = 1'b0;
      end else if (long_flagged || since(t, press_ms) >= 32'(cfg_long)) begin
        if (!long_flagged) begin
          clicks_long++;
          r.long_event = 1'b1;
        end
        click_waiting = 1'b0;
      end else if (click_waiting && since(t, click_ms) <= 32'(cfg_double)) begin
        clicks_double++;
        r.double_event = 1'b1;
        click_waiting = 1'b0;
      end else begin
        click_waiting = 1'b1;
        click_ms = t;
      end
    end
    if (lvl_stable && !long_flagged && !ignoring && since(t, press_ms) >= 32'(cfg_long)) begin
      clicks_long++;
      long_flagged = 1'b1;
      r.long_event = 1'b1;
    end
    if (click_waiting && !ignoring && since(t, click_ms) > 32'(cfg_double)) begin
      clicks_single++;
      click_waiting = 1'b0;
      r.single_event = 1'b1;
    end
    lvl_prev = raw;
    r.stable_pressed = lvl_stable;
    r.single_total = clicks_single;
    r.double_total = clicks_double;
    r.long_total = clicks_long;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_ms(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(lo, hi));
  endfunction

  task automatic send_sample(input bcc_pkg::sample_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_in = item;
    sample_valid = 1'b1;
    do @(posedge clk); while (!sample_ready);
    expected_results.push_back(classify(item));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic emit(input logic [31:0] t, input logic lvl, input logic ign);
    bcc_pkg::sample_t s;
    now = t;
    s.time_ms = t;
    s.pressed = lvl;
    s.ignore_request = ign;
    send_sample(s);
  endtask

  task automatic write_reg(input logic [bcc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bcc_pkg::REG_DEBOUNCE_MS: cfg_debounce = data;
      bcc_pkg::REG_LONG_PRESS_MS: cfg_long = data;
      bcc_pkg::REG_DOUBLE_CLICK_MS: cfg_double = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    sample_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // level held for at least dur ms, sampled at random steps, with rare bounces
  task automatic hold_level(input logic lvl, input int unsigned dur);
    logic [31:0] start;
    int unsigned step;
    start = now;
    emit(now, lvl, $urandom_range(0, 14) == 0);
    while (now - start < dur) begin
      step = $urandom_range(1, dur / 3 + 1);
      if ($urandom_range(0, 19) == 0) emit(now + step, !lvl, 1'b0);
      else emit(now + step, lvl, $urandom_range(0, 29) == 0);
    end
  endtask

  task automatic random_gesture();
    int unsigned db;
    int unsigned lp;
    int unsigned dc;
    logic lvl;
    db = 32'(cfg_debounce) + 32'd1;
    lp = 32'(cfg_long);
    dc = 32'(cfg_double);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        hold_level(1'b1, db + $urandom_range(0, lp / 2));
        hold_level(1'b0, db + $urandom_range(0, dc + 100));
      end
      3, 4: begin
        hold_level(1'b1, db + $urandom_range(0, dc / 4));
        hold_level(1'b0, db + $urandom_range(0, dc / 4));
        hold_level(1'b1, db + $urandom_range(0, dc / 4));
        hold_level(1'b0, db + $urandom_range(0, dc + 100));
      end
      5: begin
        hold_level(1'b1, db + lp + $urandom_range(0, 300));
        hold_level(1'b0, db + $urandom_range(0, dc + 100));
      end
      6: begin
        repeat ($urandom_range(1, 4))
          emit($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      7: begin
        now = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        hold_level(1'b1, db + $urandom_range(0, lp));
        hold_level(1'b0, db + $urandom_range(0, dc + 100));
      end
      8: hold_level(1'($urandom_range(0, 1)), $urandom_range(0, db + dc + 200));
      default: begin
        // level change with the timestamp standing still
        lvl = 1'($urandom_range(0, 1));
        emit(now + 32'd1, lvl, 1'b0);
        emit(now, lvl, 1'b0);
        emit(now, lvl, 1'b0);
      end
    endcase
  endtask

  task automatic test_default_clicks();
    // double click
    emit(32'd0, 1'b0, 1'b0);
    emit(32'd5, 1'b1, 1'b0);
    emit(32'd56, 1'b1, 1'b0);
    emit(32'd100, 1'b0, 1'b0);
    emit(32'd151, 1'b0, 1'b0);
    emit(32'd200, 1'b1, 1'b0);
    emit(32'd251, 1'b1, 1'b0);
    emit(32'd300, 1'b0, 1'b0);
    emit(32'd351, 1'b0, 1'b0);
    // long click while held, then a quiet release
    emit(32'd400, 1'b1, 1'b0);
    emit(32'd451, 1'b1, 1'b0);
    emit(32'd1451, 1'b1, 1'b0);
    emit(32'd1500, 1'b0, 1'b0);
    emit(32'd1551, 1'b0, 1'b0);
    // pending click survives an ignored long hold
    emit(32'd1600, 1'b1, 1'b0);
    emit(32'd1651, 1'b1, 1'b0);
    emit(32'd1700, 1'b0, 1'b0);
    emit(32'd1751, 1'b0, 1'b0);
    emit(32'd1800, 1'b1, 1'b1);
    emit(32'd1851, 1'b1, 1'b0);
    emit(32'd2900, 1'b1, 1'b0);
    emit(32'd2950, 1'b0, 1'b0);
    emit(32'd3001, 1'b0, 1'b0);
  endtask

  task automatic test_extreme_settings();
    settle();
    write_reg(bcc_pkg::REG_DEBOUNCE_MS, 16'd0);
    write_reg(bcc_pkg::REG_LONG_PRESS_MS, 16'd0);
    write_reg(bcc_pkg::REG_DOUBLE_CLICK_MS, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    emit(32'hFFFF_FFFE, 1'b1, 1'b0);
    emit(32'hFFFF_FFFE, 1'b1, 1'b0);
    emit(32'hFFFF_FFFF, 1'b1, 1'b0);
    emit(32'h0000_0000, 1'b0, 1'b0);
    emit(32'h0000_0001, 1'b0, 1'b1);
    emit(32'h0000_0002, 1'b1, 1'b0);
    emit(32'h0000_0003, 1'b1, 1'b0);
    settle();
    write_reg(bcc_pkg::REG_DEBOUNCE_MS, 16'hFFFF);
    write_reg(bcc_pkg::REG_LONG_PRESS_MS, 16'hFFFF);
    write_reg(bcc_pkg::REG_DOUBLE_CLICK_MS, 16'hFFFF);
    emit(32'h0000_0004, 1'b0, 1'b0);
    emit(32'h0001_0004, 1'b0, 1'b0);
  endtask

  task automatic test_random_gestures();
    int unsigned goal;
    int unsigned chunk;
    goal = items_sent + 920;
    while (items_sent < goal) begin
      settle();
      steady_flow = ($urandom_range(0, 4) == 0);
      write_reg(bcc_pkg::REG_DEBOUNCE_MS, pick_ms(0, 60));
      write_reg(bcc_pkg::REG_LONG_PRESS_MS, pick_ms(100, 1500));
      write_reg(bcc_pkg::REG_DOUBLE_CLICK_MS, pick_ms(50, 400));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
      chunk = items_sent + 115;
      while (items_sent < chunk && items_sent < goal) random_gesture();
    end
    steady_flow = 1'b0;
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
    end
  endtask

  always @(negedge clk) begin
    if (rst || steady_flow) begin
      ready_hold = 0;
      result_ready = 1'b1;
    end else begin
      if (ready_hold == 0 && $urandom_range(0, 3) == 0) ready_hold = pick_gap();
      if (ready_hold != 0) begin
        ready_hold--;
        result_ready = 1'b0;
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 100)
          $display("%0t: result item with nothing expected, actual %h", $time, result_out);
      end else begin
        want = expected_results.pop_front();
        check_field("stable_pressed", 32'(want.stable_pressed), 32'(result_out.stable_pressed));
        check_field("single_event", 32'(want.single_event), 32'(result_out.single_event));
        check_field("double_event", 32'(want.double_event), 32'(result_out.double_event));
        check_field("long_event", 32'(want.long_event), 32'(result_out.long_event));
        check_field("single_total", 32'(want.single_total), 32'(result_out.single_total));
        check_field("double_total", 32'(want.double_total), 32'(result_out.double_total));
        check_field("long_total", 32'(want.long_total), 32'(result_out.long_total));
        seen_single += 32'(want.single_event);
        seen_double += 32'(want.double_event);
        seen_long += 32'(want.long_event);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample_in = '0;
    result_ready = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = bcc_pkg::REG_DEBOUNCE_MS;
    cfg_data = '0;
    steady_flow = 1'b0;
    ready_hold = 0;
    items_sent = 0;
    cfg_writes = 0;
    mismatches = 0;
    seen_single = 0;
    seen_double = 0;
    seen_long = 0;
    now = '0;
    cfg_debounce = bcc_pkg::DEBOUNCE_MS_RESET;
    cfg_long = bcc_pkg::LONG_PRESS_MS_RESET;
    cfg_double = bcc_pkg::DOUBLE_CLICK_MS_RESET;
    lvl_prev = 1'b0;
    lvl_change_ms = '0;
    lvl_stable = 1'b0;
    press_ms = '0;
    long_flagged = 1'b0;
    click_waiting = 1'b0;
    click_ms = '0;
    ignoring = 1'b0;
    clicks_single = '0;
    clicks_double = '0;
    clicks_long = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_clicks();
    test_extreme_settings();
    test_random_gestures();
    settle();
    repeat (10) @(negedge clk);

    $display("covered %0d samples and %0d register writes: default, extreme and random timings",
             items_sent, cfg_writes);
    $display("clicks checked: %0d single, %0d double, %0d long",
             seen_single, seen_double, seen_long);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: button_click_classifier_core.f
+incdir+src
src/bcc_pkg.sv
src/bcc_cfg_regs.sv
src/bcc_step.sv
src/button_click_classifier_core.sv
tb/tb_button_click_classifier_core.sv
